>>> rtl/polynomial_sag_evaluator_unit_assert.svh
// assertion macros for the polynomial sag evaluator
`ifndef POLYNOMIAL_SAG_EVALUATOR_UNIT_ASSERT_SVH
`define POLYNOMIAL_SAG_EVALUATOR_UNIT_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define PSAG_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psag check failed");

// condition holds in the cycle after the trigger
`define PSAG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psag check failed");

`endif

>>> rtl/psag_pkg.sv
`timescale 1ns / 1ps

package psag_pkg;

  localparam int MODE_W    = 2;
  localparam int RADIUS_W  = 32;
  localparam int TERM_W    = 4;
  localparam int VALUE_W   = 64;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 4;

  // item modes
  localparam logic [MODE_W-1:0] MODE_SAGITTA    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DERIVATIVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE      = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_EXP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_EXP  = 1'd1;

  // saturation bounds, as magnitudes
  localparam logic [VALUE_W-1:0] MAG_NEG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] MAG_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic               en;
    logic [TERM_W-1:0]  index;
    logic [VALUE_W-1:0] data;
  } psag_mem_wr_t;

  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    logic               neg;
    logic               ovf;
  } psag_mul_res_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               ovf;
  } psag_weight_res_t;

endpackage

>>> rtl/psag_if.sv
`timescale 1ns / 1ps

interface psag_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [psag_pkg::MODE_W-1:0]          mode;
  logic signed [psag_pkg::RADIUS_W-1:0] radius;
  logic [psag_pkg::TERM_W-1:0]          coefficient_index;
  logic signed [psag_pkg::VALUE_W-1:0]  coefficient_value;

  modport source (output valid, mode, radius, coefficient_index, coefficient_value,
                  input ready);
  modport sink (input valid, mode, radius, coefficient_index, coefficient_value,
                output ready);
endinterface

interface psag_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [psag_pkg::VALUE_W-1:0] value;
  logic                                overflow;

  modport source (output valid, value, overflow, input ready);
  modport sink (input valid, value, overflow, output ready);
endinterface

>>> rtl/psag_coef_mem.sv
`timescale 1ns / 1ps

module psag_coef_mem #(
  parameter int TERM_COUNT = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  psag_pkg::psag_mem_wr_t             wr,
  input  logic [psag_pkg::TERM_W-1:0]        rd_index,
  output logic [psag_pkg::VALUE_W-1:0]       rd_data
);

  localparam int AW = $clog2(TERM_COUNT);

  logic [psag_pkg::VALUE_W-1:0] mem [TERM_COUNT];
  logic [TERM_COUNT-1:0]        valid;
  logic [AW-1:0]                wr_addr;
  logic [AW-1:0]                rd_addr;
  logic                         wr_hit;
  logic                         rd_hit;
  logic [psag_pkg::VALUE_W-1:0] rd_q;
  logic                         rd_ok;

  // indexes past the store are dropped on write and read back as zero
  assign wr_addr = AW'(wr.index);
  assign rd_addr = AW'(rd_index);
  assign wr_hit  = wr.en && (32'(wr.index) < 32'(TERM_COUNT));
  assign rd_hit  = 32'(rd_index) < 32'(TERM_COUNT);

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_addr] <= wr.data;
    end
    rd_q <= mem[rd_addr];
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr_hit) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_ok <= rd_hit && valid[rd_addr];
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

>>> rtl/psag_mul.sv
`timescale 1ns / 1ps

module psag_mul (
  input  logic                          clk,
  input  logic [psag_pkg::VALUE_W-1:0]  y,
  input  logic [psag_pkg::RADIUS_W-1:0] r_mag,
  input  logic                          r_neg,
  output psag_pkg::psag_mul_res_t       res
);

  localparam logic [63:0] ROUND_BIAS = 64'h0000_0000_0080_0000;

  logic [63:0] ym_q;
  logic        neg1;
  logic [63:0] lo_q;
  logic [31:0] ym_hi_q;
  logic        neg2;
  logic [63:0] hi_q;
  logic [39:0] lo_r_q;
  logic        neg3;
  logic [63:0] lo_rnd;
  logic [72:0] sum;
  logic [63:0] mag;
  logic [63:0] lim;

  // stage 1: magnitude of y and product sign
  always_ff @(posedge clk) begin
    ym_q <= y[63] ? (~y + 64'd1) : y;
    neg1 <= y[63] ^ r_neg;
  end

  // stage 2: low partial product
  always_ff @(posedge clk) begin
    lo_q    <= {32'd0, ym_q[31:0]} * {32'd0, r_mag};
    ym_hi_q <= ym_q[63:32];
    neg2    <= neg1;
  end

  // stage 3: high partial product, round the low part
  assign lo_rnd = lo_q + ROUND_BIAS;

  always_ff @(posedge clk) begin
    hi_q   <= {32'd0, ym_hi_q} * {32'd0, r_mag};
    lo_r_q <= lo_rnd[63:24];
    neg3   <= neg2;
  end

  // stage 4: combine, saturate the magnitude
  always_comb begin
    sum = {1'b0, hi_q, 8'd0} + {33'd0, lo_r_q};
    mag = (|sum[72:64]) ? '1 : sum[63:0];
    lim = neg3 ? psag_pkg::MAG_NEG_LIMIT : psag_pkg::MAG_POS_LIMIT;
  end

  always_ff @(posedge clk) begin
    res.neg <= neg3;
    res.ovf <= mag > lim;
    res.mag <= (mag > lim) ? lim : mag;
  end

endmodule

>>> rtl/psag_weight.sv
`timescale 1ns / 1ps

module psag_weight (
  input  logic                         clk,
  input  logic [psag_pkg::VALUE_W-1:0] coef,
  input  logic [psag_pkg::TERM_W-1:0]  factor,
  output psag_pkg::psag_weight_res_t   res
);

  logic [63:0] cmag_q;
  logic        neg1;
  logic [3:0]  fac_q;
  logic [67:0] prod_q;
  logic        neg2;
  logic [67:0] lim;
  logic        over;
  logic [63:0] clamped;

  always_ff @(posedge clk) begin
    cmag_q <= coef[63] ? (~coef + 64'd1) : coef;
    neg1   <= coef[63];
    fac_q  <= factor;
  end

  // narrow multiply by the exponent
  always_ff @(posedge clk) begin
    prod_q <= {4'd0, cmag_q} * fac_q;
    neg2   <= neg1;
  end

  always_comb begin
    lim     = neg2 ? {4'd0, psag_pkg::MAG_NEG_LIMIT} : {4'd0, psag_pkg::MAG_POS_LIMIT};
    over    = prod_q > lim;
    clamped = over ? lim[63:0] : prod_q[63:0];
  end

  always_ff @(posedge clk) begin
    res.ovf   <= over;
    res.value <= neg2 ? (~clamped + 64'd1) : clamped;
  end

endmodule

>>> rtl/polynomial_sag_evaluator_unit.sv
`timescale 1ns / 1ps
// an evaluation runs n steps, hi = last raised to first, n = Horner terms plus
// power steps (sagitta: hi-first+1 + first; derivative: hi-lo+1 + lo-1)
// items are taken only while idle, so a new evaluation waits for the last to finish;
// each step runs the four multiply stages and the accumulate; writes finish when taken
// reset: synchronous, clears control, config and the store's valid bits (no clearing pass)
`include "polynomial_sag_evaluator_unit_assert.svh"

module polynomial_sag_evaluator_unit #(
  parameter int TERM_COUNT = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [psag_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psag_pkg::CFG_DATA_W-1:0]     cfg_data,
  psag_in_if.sink                             req,
  psag_out_if.source                          rsp
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  // one step: read and multiply stages fill, the last phase accumulates
  localparam logic [2:0] PHASE_LAST = 3'd4;

  state_t                       state;
  logic [2:0]                   phase;
  logic [psag_pkg::TERM_W-1:0]  first_exp;
  logic [psag_pkg::TERM_W-1:0]  last_exp;
  logic [psag_pkg::TERM_W-1:0]  cur;
  logic [psag_pkg::TERM_W-1:0]  term_lo;
  logic [psag_pkg::TERM_W-1:0]  power_left;
  logic                         in_power;
  logic                         deriv;
  logic [psag_pkg::RADIUS_W-1:0] r_mag;
  logic                         r_neg;
  logic [psag_pkg::VALUE_W-1:0] y;
  logic                         ovf_acc;
  logic                         rsp_valid;
  logic [psag_pkg::VALUE_W-1:0] rsp_value;
  logic                         rsp_overflow;

  logic                         req_fire;
  logic [psag_pkg::TERM_W-1:0]  hi_eff;
  logic [psag_pkg::TERM_W-1:0]  lo_deriv;
  logic [psag_pkg::TERM_W-1:0]  factor;
  logic [psag_pkg::VALUE_W-1:0] coef;
  logic [psag_pkg::VALUE_W-1:0] y_next;
  logic                         add_ovf;
  logic signed [65:0]           acc_a;
  logic signed [65:0]           acc_m;
  logic signed [65:0]           acc_sum;

  psag_pkg::psag_mem_wr_t       mem_wr;
  psag_pkg::psag_mul_res_t      mul_res;
  psag_pkg::psag_weight_res_t   w_res;

  // no item is taken while reset is held
  assign req.ready    = (state == ST_IDLE) && !rst;
  assign req_fire     = req.valid && req.ready;
  assign rsp.valid    = rsp_valid;
  assign rsp.value    = rsp_value;
  assign rsp.overflow = rsp_overflow;

  // effective term range: last raised to first, derivative starts no lower than exponent one
  assign hi_eff   = (last_exp < first_exp) ? first_exp : last_exp;
  assign lo_deriv = (first_exp == '0) ? 4'd1 : first_exp;

  // coefficient writes go straight to the store
  always_comb begin
    mem_wr.en    = req_fire && (req.mode == psag_pkg::MODE_WRITE);
    mem_wr.index = req.coefficient_index;
    mem_wr.data  = req.coefficient_value;
  end

  psag_coef_mem #(
    .TERM_COUNT (TERM_COUNT)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr       (mem_wr),
    .rd_index (cur),
    .rd_data  (coef)
  );

  // power steps add nothing, sagitta terms pass unweighted
  assign factor = in_power ? 4'd0 : (deriv ? cur : 4'd1);

  psag_weight u_weight (
    .clk    (clk),
    .coef   (coef),
    .factor (factor),
    .res    (w_res)
  );

  psag_mul u_mul (
    .clk   (clk),
    .y     (y),
    .r_mag (r_mag),
    .r_neg (r_neg),
    .res   (mul_res)
  );

  // signed product plus weighted coefficient, saturated in one add
  always_comb begin
    acc_a   = {{2{w_res.value[63]}}, w_res.value};
    acc_m   = {2'b00, mul_res.mag};
    acc_sum = mul_res.neg ? (acc_a - acc_m) : (acc_a + acc_m);
    add_ovf = (acc_sum[65:63] != 3'b000) && (acc_sum[65:63] != 3'b111);
    if (!add_ovf) begin
      y_next = acc_sum[63:0];
    end else if (acc_sum[65]) begin
      y_next = psag_pkg::MAG_NEG_LIMIT;
    end else begin
      y_next = psag_pkg::MAG_POS_LIMIT;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_exp <= '0;
      last_exp  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        psag_pkg::CFG_FIRST_EXP: first_exp <= cfg_data;
        psag_pkg::CFG_LAST_EXP:  last_exp  <= cfg_data;
        default: ;
      endcase
    end
  end

  // r magnitude and sign held for the whole evaluation
  always_ff @(posedge clk) begin
    if (req_fire) begin
      r_mag <= req.radius[31] ? (~req.radius + 32'd1) : req.radius;
      r_neg <= req.radius[31];
    end
  end

  // sequencer: Horner terms from the top exponent down, then the power steps
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= '0;
      cur        <= '0;
      term_lo    <= '0;
      power_left <= '0;
      in_power   <= 1'b0;
      deriv      <= 1'b0;
      y          <= '0;
      ovf_acc    <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      // result taken; a finishing evaluation refills the register below
      if (rsp_valid && rsp.ready && (state != ST_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            y        <= '0;
            ovf_acc  <= 1'b0;
            phase    <= '0;
            in_power <= 1'b0;
            case (req.mode)
              psag_pkg::MODE_SAGITTA: begin
                deriv      <= 1'b0;
                cur        <= hi_eff;
                term_lo    <= first_exp;
                power_left <= first_exp;
                state      <= ST_RUN;
              end
              psag_pkg::MODE_DERIVATIVE: begin
                deriv      <= 1'b1;
                cur        <= hi_eff;
                term_lo    <= lo_deriv;
                power_left <= lo_deriv - 4'd1;
                // empty range gives zero with no overflow
                state      <= (hi_eff < lo_deriv) ? ST_FINISH : ST_RUN;
              end
              default: ;
            endcase
          end
        end
        ST_RUN: begin
          if (phase == PHASE_LAST) begin
            phase   <= '0;
            y       <= y_next;
            ovf_acc <= ovf_acc | mul_res.ovf | w_res.ovf | add_ovf;
            if (!in_power) begin
              if (cur == term_lo) begin
                if (power_left == '0) begin
                  state <= ST_FINISH;
                end else begin
                  in_power <= 1'b1;
                end
              end else begin
                cur <= cur - 4'd1;
              end
            end else begin
              if (power_left == 4'd1) begin
                state <= ST_FINISH;
              end
              power_left <= power_left - 4'd1;
            end
          end else begin
            phase <= phase + 3'd1;
          end
        end
        ST_FINISH: begin
          // output register free or being emptied this cycle
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!rsp_valid || rsp.ready)) begin
      rsp_value    <= y;
      rsp_overflow <= ovf_acc;
    end
  end

  // a result only ever appears after an evaluation has finished
  `PSAG_ASSERT_SAME(a_rsp_from_finish, clk, rst, $rose(rsp_valid), $past(state == ST_FINISH))
  // a coefficient write never starts an evaluation
  `PSAG_ASSERT_NEXT(a_write_stays_idle, clk, rst, req_fire && (req.mode == psag_pkg::MODE_WRITE), state == ST_IDLE)
  // step phase stays within the multiply loop
  `PSAG_ASSERT_SAME(a_phase_range, clk, rst, state == ST_RUN, phase <= PHASE_LAST)
  // power steps only run while some remain
  `PSAG_ASSERT_SAME(a_power_count, clk, rst, (state == ST_RUN) && in_power, power_left != '0)

endmodule

>>> test/polynomial_sag_evaluator_unit_test.sv
`timescale 1ns / 1ps

module polynomial_sag_evaluator_unit_test;

  localparam int MODE_W     = psag_pkg::MODE_W;
  localparam int RADIUS_W   = psag_pkg::RADIUS_W;
  localparam int TERM_W     = psag_pkg::TERM_W;
  localparam int VALUE_W    = psag_pkg::VALUE_W;
  localparam int CFG_IDX_W  = psag_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = psag_pkg::CFG_DATA_W;

  localparam logic [MODE_W-1:0]     MODE_SAGITTA    = psag_pkg::MODE_SAGITTA;
  localparam logic [MODE_W-1:0]     MODE_DERIVATIVE = psag_pkg::MODE_DERIVATIVE;
  localparam logic [MODE_W-1:0]     MODE_WRITE      = psag_pkg::MODE_WRITE;
  localparam logic [CFG_IDX_W-1:0]  CFG_FIRST_EXP   = psag_pkg::CFG_FIRST_EXP;
  localparam logic [CFG_IDX_W-1:0]  CFG_LAST_EXP    = psag_pkg::CFG_LAST_EXP;
  localparam logic [VALUE_W-1:0]    MAG_NEG_LIMIT   = psag_pkg::MAG_NEG_LIMIT;
  localparam logic [VALUE_W-1:0]    MAG_POS_LIMIT   = psag_pkg::MAG_POS_LIMIT;

  localparam int TERMS            = 16;
  // settle time after the last owed result, enough to cover anything still in flight
  localparam int DRAIN_CYCLES     = 170;
  // cycles with no item moving on either side before the run is called hung
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int PHASES           = 8;
  localparam int ITEMS_PER_PHASE  = 100;
  localparam int DIRECTED_ROWS    = 27;

  // mode 3 has no name in the package; the block must ignore it
  localparam logic [MODE_W-1:0]   MODE_UNUSED = 2'd3;

  // handy fixed-point values
  localparam logic [VALUE_W-1:0]  Q48_ONE     = 64'h0001_0000_0000_0000;
  localparam logic [VALUE_W-1:0]  Q48_NEG_ONE = 64'hFFFF_0000_0000_0000;
  localparam logic [VALUE_W-1:0]  Q48_THREE   = 64'h0003_0000_0000_0000;
  localparam logic [VALUE_W-1:0]  Q48_FIFTEEN = 64'h000F_0000_0000_0000;
  localparam logic [VALUE_W-1:0]  ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [RADIUS_W-1:0] Q24_ONE     = 32'h0100_0000;
  localparam logic [RADIUS_W-1:0] Q24_HALF    = 32'h0080_0000;
  localparam logic [RADIUS_W-1:0] R_MAX       = 32'h7FFF_FFFF;
  localparam logic [RADIUS_W-1:0] R_MIN       = 32'h8000_0000;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [RADIUS_W-1:0] radius;
    logic [TERM_W-1:0]   index;
    logic [VALUE_W-1:0]  coef;
  } sag_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               overflow;
  } sag_result_t;

  typedef enum logic {ROW_TERMS, ROW_ITEM} row_kind_t;

  // one row of the directed table: either a new term range or an item,
  // optionally with its result typed in by hand
  typedef struct packed {
    row_kind_t         kind;
    logic [TERM_W-1:0] first;
    logic [TERM_W-1:0] last;
    sag_item_t         item;
    logic              typed;
    sag_result_t       typed_result;
  } directed_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  sink_ready = 1'b0;
  int                    ready_hold = 0;
  int                    idle_cycles = 0;
  int                    fail_count = 0;

  // predictor state: own copy of the coefficient store and the term range
  logic [VALUE_W-1:0]    coefficient_model [TERMS];
  logic [TERM_W-1:0]     first_exp_model;
  logic [TERM_W-1:0]     last_exp_model;
  logic                  step_saturated;

  // sagitta and derivative values still owed by the block, oldest first
  sag_result_t           pending_sags [$];

  // term range for the first six random phases, first in the upper nibble; the extremes come first
  logic [7:0] term_settings [6] = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h39, 8'h01};

  // directed table: reset state, field extremes, every mode, saturation,
  // the ignored mode, last below first and the derivative with first term 0
  directed_row_t directed_table [DIRECTED_ROWS] = '{
    // store and range straight out of reset: everything is zero
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_SAGITTA, Q24_ONE, 4'd0, 64'd0}, 1'b1, '{64'd0, 1'b0}},
    // derivative over 0..0 is an empty sum
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_DERIVATIVE, R_MAX, 4'd0, 64'd0}, 1'b1, '{64'd0, 1'b0}},
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_WRITE, 32'd0, 4'd0, Q48_ONE}, 1'b0, '{64'd0, 1'b0}},
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_SAGITTA, R_MIN, 4'd0, 64'd0}, 1'b1, '{Q48_ONE, 1'b0}},
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_WRITE, 32'd0, 4'd0, MAG_POS_LIMIT}, 1'b0, '{64'd0, 1'b0}},
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_SAGITTA, 32'd0, 4'd0, 64'd0}, 1'b1,
      '{MAG_POS_LIMIT, 1'b0}},
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_WRITE, 32'd0, 4'd0, MAG_NEG_LIMIT}, 1'b0, '{64'd0, 1'b0}},
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_SAGITTA, R_MAX, 4'd0, 64'd0}, 1'b1,
      '{MAG_NEG_LIMIT, 1'b0}},
    // unused mode with every other field at its top: nothing may change
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_UNUSED, 32'hFFFF_FFFF, 4'd15, ALL_ONES}, 1'b0,
      '{64'd0, 1'b0}},
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_SAGITTA, 32'd0, 4'd0, 64'd0}, 1'b1,
      '{MAG_NEG_LIMIT, 1'b0}},
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_WRITE, 32'd0, 4'd15, Q48_ONE}, 1'b0, '{64'd0, 1'b0}},
    '{ROW_TERMS, 4'd15, 4'd15, '{MODE_SAGITTA, 32'd0, 4'd0, 64'd0}, 1'b0, '{64'd0, 1'b0}},
    // r to the fifteenth with r zero wipes the sum
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_SAGITTA, 32'd0, 4'd0, 64'd0}, 1'b1, '{64'd0, 1'b0}},
    // top exponent weights the coefficient by fifteen
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_DERIVATIVE, Q24_ONE, 4'd0, 64'd0}, 1'b1,
      '{Q48_FIFTEEN, 1'b0}},
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_WRITE, 32'd0, 4'd15, MAG_POS_LIMIT}, 1'b0, '{64'd0, 1'b0}},
    // weighting the largest coefficient saturates and raises the flag
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_DERIVATIVE, Q24_ONE, 4'd0, 64'd0}, 1'b1,
      '{MAG_POS_LIMIT, 1'b1}},
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_WRITE, 32'd0, 4'd15, Q48_NEG_ONE}, 1'b0, '{64'd0, 1'b0}},
    '{ROW_TERMS, 4'd0, 4'd15, '{MODE_SAGITTA, 32'd0, 4'd0, 64'd0}, 1'b0, '{64'd0, 1'b0}},
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_SAGITTA, R_MAX, 4'd0, 64'd0}, 1'b0, '{64'd0, 1'b0}},
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_SAGITTA, R_MIN, 4'd0, 64'd0}, 1'b0, '{64'd0, 1'b0}},
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_DERIVATIVE, R_MIN, 4'd0, 64'd0}, 1'b0, '{64'd0, 1'b0}},
    // last below first: the range collapses onto the first term
    '{ROW_TERMS, 4'd5, 4'd2, '{MODE_SAGITTA, 32'd0, 4'd0, 64'd0}, 1'b0, '{64'd0, 1'b0}},
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_WRITE, 32'd0, 4'd5, Q48_THREE}, 1'b0, '{64'd0, 1'b0}},
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_SAGITTA, Q24_ONE, 4'd0, 64'd0}, 1'b1, '{Q48_THREE, 1'b0}},
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_DERIVATIVE, Q24_HALF, 4'd0, 64'd0}, 1'b0, '{64'd0, 1'b0}},
    // derivative starting at term 0 is taken from term 1
    '{ROW_TERMS, 4'd0, 4'd3, '{MODE_SAGITTA, 32'd0, 4'd0, 64'd0}, 1'b0, '{64'd0, 1'b0}},
    '{ROW_ITEM, 4'd0, 4'd0, '{MODE_DERIVATIVE, Q24_ONE, 4'd0, 64'd0}, 1'b0, '{64'd0, 1'b0}}
  };

  psag_in_if  req_bus ();
  psag_out_if rsp_bus ();

  assign rsp_bus.ready = sink_ready;

  polynomial_sag_evaluator_unit #(
    .TERM_COUNT(TERMS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_bus),
    .rsp       (rsp_bus)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // put a sign on a magnitude and clamp to the signed 64-bit range
  function automatic logic [VALUE_W-1:0] sign_saturate(input logic [VALUE_W-1:0] mag,
                                                       input logic neg);
    if (neg) begin
      if (mag > MAG_NEG_LIMIT) begin
        step_saturated = 1'b1;
        mag = MAG_NEG_LIMIT;
      end
      return 64'd0 - mag;
    end
    if (mag > MAG_POS_LIMIT) begin
      step_saturated = 1'b1;
      mag = MAG_POS_LIMIT;
    end
    return mag;
  endfunction

  // Q16.48 times Q8.24: exact magnitude product, half rounded away from zero
  function automatic logic [VALUE_W-1:0] scale_by_radius(input logic [VALUE_W-1:0] y,
                                                         input logic [RADIUS_W-1:0] r);
    logic [VALUE_W-1:0]  y_mag;
    logic [RADIUS_W-1:0] r_mag;
    logic [96:0]         product;
    logic [VALUE_W-1:0]  mag;
    y_mag = y[VALUE_W-1] ? 64'd0 - y : y;
    r_mag = r[RADIUS_W-1] ? 32'd0 - r : r;
    product = (97'(y_mag) * 97'(r_mag) + (97'd1 << 23)) >> 24;
    mag = (product[96:64] != '0) ? ALL_ONES : product[63:0];
    return sign_saturate(mag, y[VALUE_W-1] ^ r[RADIUS_W-1]);
  endfunction

  function automatic logic [VALUE_W-1:0] add_saturate(input logic [VALUE_W-1:0] a,
                                                      input logic [VALUE_W-1:0] b);
    logic [VALUE_W-1:0] sum;
    sum = a + b;
    if (a[VALUE_W-1] == b[VALUE_W-1] && sum[VALUE_W-1] != a[VALUE_W-1]) begin
      step_saturated = 1'b1;
      return a[VALUE_W-1] ? MAG_NEG_LIMIT : MAG_POS_LIMIT;
    end
    return sum;
  endfunction

  // coefficient times its exponent, clamped
  function automatic logic [VALUE_W-1:0] weight_by_exponent(input logic [VALUE_W-1:0] c,
                                                            input int exponent);
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [71:0]        product;
    neg = c[VALUE_W-1];
    mag = neg ? 64'd0 - c : c;
    product = 72'(mag) * 72'(exponent);
    if (product > 72'(neg ? MAG_NEG_LIMIT : MAG_POS_LIMIT)) begin
      step_saturated = 1'b1;
      return neg ? MAG_NEG_LIMIT : MAG_POS_LIMIT;
    end
    return neg ? 64'd0 - product[63:0] : product[63:0];
  endfunction

  function automatic sag_result_t evaluate_polynomial(input logic [MODE_W-1:0] mode,
                                                      input logic [RADIUS_W-1:0] r);
    int                 lo;
    int                 hi;
    logic [VALUE_W-1:0] acc;
    sag_result_t        res;
    step_saturated = 1'b0;
    acc = '0;
    // a last term below the first is raised to it
    hi = int'((last_exp_model < first_exp_model) ? first_exp_model : last_exp_model);
    if (mode == MODE_SAGITTA) begin
      lo = int'(first_exp_model);
      for (int i = hi; i >= lo; i--) begin
        acc = scale_by_radius(acc, r);
        acc = add_saturate(acc, coefficient_model[i]);
      end
      repeat (lo) acc = scale_by_radius(acc, r);
    end else begin
      // no r to the minus one: a first term of 0 counts as 1, possibly leaving no terms
      lo = (first_exp_model == '0) ? 1 : int'(first_exp_model);
      if (hi >= lo) begin
        for (int i = hi; i >= lo; i--) begin
          acc = scale_by_radius(acc, r);
          acc = add_saturate(acc, weight_by_exponent(coefficient_model[i], i));
        end
        repeat (lo - 1) acc = scale_by_radius(acc, r);
      end
    end
    res.value = acc;
    res.overflow = step_saturated;
    return res;
  endfunction

  // updates the store for writes; returns 1 when the item yields a result
  function automatic bit predict_sag(input sag_item_t item, output sag_result_t res);
    res = '0;
    if (item.mode == MODE_WRITE) begin
      coefficient_model[item.index] = item.coef;
      return 1'b0;
    end
    if (item.mode == MODE_UNUSED) return 1'b0;
    res = evaluate_polynomial(item.mode, item.radius);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // random picks
  // ---------------------------------------------------------------------------

  // mostly back to back, now and then a long pause
  function automatic int pick_gap(input bit burst);
    int roll;
    if (burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // small radii keep long sums out of saturation; others are random or hit the edges
  function automatic logic [RADIUS_W-1:0] pick_radius();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $urandom_range(0, 32'h03FF_FFFF) - 32'h0200_0000;
    if (roll < 60) return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    if (roll < 80) return $urandom;
    case ($urandom_range(0, 4))
      0: return '0;
      1: return Q24_ONE;
      2: return 32'd0 - Q24_ONE;
      3: return R_MAX;
      default: return R_MIN;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_coefficient();
    int                 roll;
    logic [VALUE_W-1:0] raw;
    raw = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    if (roll < 40) return $signed(raw) >>> 12;
    if (roll < 60) return $signed(raw) >>> 20;
    if (roll < 85) return raw;
    case ($urandom_range(0, 4))
      0: return '0;
      1: return Q48_ONE;
      2: return Q48_NEG_ONE;
      3: return MAG_POS_LIMIT;
      default: return MAG_NEG_LIMIT;
    endcase
  endfunction

  // evaluations somewhat more often than writes, a few ignored items
  function automatic sag_item_t random_item();
    sag_item_t item;
    int        roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) item.mode = MODE_SAGITTA;
    else if (roll < 60) item.mode = MODE_DERIVATIVE;
    else if (roll < 95) item.mode = MODE_WRITE;
    else item.mode = MODE_UNUSED;
    item.radius = pick_radius();
    item.index = 4'($urandom_range(0, 15));
    item.coef = pick_coefficient();
    return item;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // called at a rising edge; returns at the edge where the item is taken
  task automatic offer_item(input sag_item_t item, input int gap, input logic typed,
                            input sag_result_t typed_result);
    sag_result_t predicted;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid             <= 1'b1;
    req_bus.mode              <= item.mode;
    req_bus.radius            <= item.radius;
    req_bus.coefficient_index <= item.index;
    req_bus.coefficient_value <= item.coef;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    // hand-typed rows are checked against their own value, not the predictor's
    if (predict_sag(item, predicted)) begin
      pending_sags.insert(pending_sags.size(), typed ? typed_result : predicted);
    end
  endtask

  // stop sending and wait for every owed result, then optionally let the block settle
  task automatic drain_results(input int settle);
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_sags.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // term range changes only with the block idle; owed results are drained first
  task automatic set_terms(input logic [TERM_W-1:0] first, input logic [TERM_W-1:0] last);
    drain_results(DRAIN_CYCLES);
    cfg_write <= 1'b1;
    cfg_index <= CFG_FIRST_EXP;
    cfg_data  <= first;
    @(posedge clk);
    first_exp_model = first;
    cfg_index <= CFG_LAST_EXP;
    cfg_data  <= last;
    @(posedge clk);
    last_exp_model = last;
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    sag_item_t item;
    bit        burst;
    int        counted;
    rst                       <= 1'b1;
    cfg_write                 <= 1'b0;
    cfg_index                 <= CFG_FIRST_EXP;
    cfg_data                  <= '0;
    req_bus.valid             <= 1'b0;
    req_bus.mode              <= MODE_SAGITTA;
    req_bus.radius            <= '0;
    req_bus.coefficient_index <= '0;
    req_bus.coefficient_value <= '0;
    for (int k = 0; k < TERMS; k++) coefficient_model[k] = '0;
    first_exp_model = '0;
    last_exp_model  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int n = 0; n < DIRECTED_ROWS; n++) begin
      if (directed_table[n].kind == ROW_TERMS) begin
        set_terms(directed_table[n].first, directed_table[n].last);
      end else begin
        offer_item(directed_table[n].item, pick_gap(1'b0), directed_table[n].typed,
                   directed_table[n].typed_result);
      end
    end

    // random phases, each under its own term range; ignored items are not counted
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 6) begin
        set_terms(term_settings[phase][7:4], term_settings[phase][3:0]);
      end else begin
        set_terms(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end
      // some phases send without any gaps at all
      burst = ($urandom_range(0, 3) == 0);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        item = random_item();
        if (item.mode != MODE_UNUSED) counted++;
        offer_item(item, pick_gap(burst), 1'b0, '0);
        // hold the sender off mid-phase until nothing is owed
        if (phase == 2 && counted == ITEMS_PER_PHASE / 2) drain_results(0);
      end
    end

    drain_results(DRAIN_CYCLES);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // ready in runs: short bursts, long open stretches, short and long stalls
  always @(posedge clk) begin : drive_ready
    int roll;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        sink_ready <= 1'b1;
        ready_hold <= $urandom_range(0, 7);
      end else if (roll < 70) begin
        sink_ready <= 1'b1;
        ready_hold <= $urandom_range(50, 150);
      end else if (roll < 95) begin
        sink_ready <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        sink_ready <= 1'b0;
        ready_hold <= $urandom_range(20, 60);
      end
    end
  end

  // every result taken is matched against the oldest owed one
  always @(posedge clk) begin : check_results
    sag_result_t want;
    if (!rst && rsp_bus.valid && sink_ready) begin
      if (pending_sags.size() == 0) begin
        $error("result with none owed: value %h overflow %b", rsp_bus.value,
               rsp_bus.overflow);
        fail_count++;
      end else begin
        want = pending_sags.pop_front();
        if (rsp_bus.value !== want.value) begin
          $error("value: expected %h, got %h", want.value, rsp_bus.value);
          fail_count++;
        end
        if (rsp_bus.overflow !== want.overflow) begin
          $error("overflow: expected %b, got %b", want.overflow, rsp_bus.overflow);
          fail_count++;
        end
      end
    end
  end

  // hang detection: count cycles with no item moving on either side
  always @(posedge clk) begin : watchdog
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && sink_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> polynomial_sag_evaluator_unit.f
+incdir+rtl
rtl/psag_pkg.sv
rtl/psag_if.sv
rtl/psag_coef_mem.sv
rtl/psag_mul.sv
rtl/psag_weight.sv
rtl/polynomial_sag_evaluator_unit.sv
test/polynomial_sag_evaluator_unit_test.sv
